/* hdl/stalu_pkg.sv */
// ----------------------------------------------------------------------------
// stalu_pkg
// Shared types and constants for the seconds/microseconds time ALU.
// ----------------------------------------------------------------------------
package stalu_pkg;

  localparam int unsigned SEC_W        = 32;
  localparam int unsigned USEC_W       = 20;
  localparam int unsigned NS_W         = 30;
  localparam int unsigned NUM_W        = 53;  // total microseconds, signed or magnitude
  localparam int unsigned DEN_W        = 32;
  localparam int unsigned USEC_PER_SEC = 1000000;
  localparam int unsigned NS_PER_USEC  = 1000;

  // microsecond split: 1000000 = 64 * 15625, divided in 16-bit chunks
  localparam int unsigned USEC_SHIFT   = 6;
  localparam int unsigned USEC_ODD     = USEC_PER_SEC >> USEC_SHIFT;
  localparam int unsigned ODD_W        = 14;
  localparam int unsigned CHUNK_W      = 16;
  localparam int unsigned SPLIT_STEPS  = 3;
  localparam int unsigned SPLIT_W      = USEC_SHIFT + SPLIT_STEPS * CHUNK_W;
  localparam int unsigned QUO_W        = SPLIT_STEPS * CHUNK_W;
  localparam int unsigned Y_W          = ODD_W + CHUNK_W;
  // reciprocal exact for every Y_W-bit dividend: ceil(2^(Y_W+ODD_W) / USEC_ODD)
  localparam int unsigned RECIP_SHIFT  = Y_W + ODD_W;
  localparam int unsigned RECIP_W      = 31;
  localparam int unsigned PROD_W       = Y_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_M =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(USEC_ODD) - 64'd1) / 64'(USEC_ODD));

  typedef enum logic [2:0] {
    KIND_ADD   = 3'd0,
    KIND_SUB   = 3'd1,
    KIND_CMP   = 3'd2,
    KIND_MUL   = 3'd3,
    KIND_DIV   = 3'd4,
    KIND_SMALL = 3'd5
  } kind_e;

  localparam logic [1:0] ORDER_EQ = 2'b00;
  localparam logic [1:0] ORDER_GT = 2'b01;
  localparam logic [1:0] ORDER_LT = 2'b11;

  // context that travels beside the dividers
  typedef struct packed {
    logic [2:0]             kind;
    logic [SEC_W-1:0]       base;   // seconds before the quotient is added
    logic signed [NUM_W-1:0] p;     // microseconds still to be split
    logic [1:0]             order;
    logic                   dz;
    logic                   neg;    // sign of the value being split
  } ctx_t;

endpackage

/* hdl/stalu_div.sv */
// ----------------------------------------------------------------------------
// stalu_div
// Unsigned restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module stalu_div import stalu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  ctx_t             ctx_i,
  output logic             valid_o,
  output logic [NUM_W-1:0] quo_o,
  output logic [DEN_W-1:0] rem_o,
  output ctx_t             ctx_o
);

  logic             vld_q [NUM_W];
  logic [DEN_W-1:0] rem_q [NUM_W];
  logic [NUM_W-1:0] num_q [NUM_W];
  logic [DEN_W-1:0] den_q [NUM_W];
  ctx_t             ctx_q [NUM_W];

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic             vld_in;
    logic [DEN_W-1:0] rem_in;
    logic [NUM_W-1:0] num_in;
    logic [DEN_W-1:0] den_in;
    ctx_t             ctx_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (s == 0) begin : g_first
      assign vld_in = valid_i;
      assign rem_in = '0;
      assign num_in = num_i;
      assign den_in = den_i;
      assign ctx_in = ctx_i;
    end else begin : g_next
      assign vld_in = vld_q[s-1];
      assign rem_in = rem_q[s-1];
      assign num_in = num_q[s-1];
      assign den_in = den_q[s-1];
      assign ctx_in = ctx_q[s-1];
    end

    assign trial = {rem_in, num_in[NUM_W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    // shift the dividend out at the top, quotient bits in at the bottom
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        num_q[s] <= {num_in[NUM_W-2:0], ge};
        den_q[s] <= den_in;
        ctx_q[s] <= ctx_in;
      end
    end
  end

  assign valid_o = vld_q[NUM_W-1];
  assign quo_o   = num_q[NUM_W-1];
  assign rem_o   = rem_q[NUM_W-1];
  assign ctx_o   = ctx_q[NUM_W-1];

endmodule

/* hdl/stalu_front.sv */
// ----------------------------------------------------------------------------
// stalu_front
// Operand capture, products, sums and magnitudes ahead of the dividers.
// ----------------------------------------------------------------------------
module stalu_front import stalu_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [2:0]              kind_i,
  input  logic signed [SEC_W-1:0] a_sec_i,
  input  logic [USEC_W-1:0]       a_usec_i,
  input  logic signed [SEC_W-1:0] b_sec_i,
  input  logic [USEC_W-1:0]       b_usec_i,
  input  logic signed [DEN_W-1:0] factor_i,
  output logic                    valid_o,
  output logic [NUM_W-1:0]        mt_o,
  output logic [DEN_W-1:0]        mf_o,
  output ctx_t                    ctx_o
);

  localparam logic signed [USEC_W:0] USEC_S = (USEC_W+1)'(USEC_PER_SEC);

  // stage 0: captured operands
  logic                    v0_q;
  logic [2:0]              kind0_q;
  logic signed [SEC_W-1:0] as0_q, bs0_q;
  logic [USEC_W-1:0]       au0_q, bu0_q;
  logic signed [DEN_W-1:0] f0_q;

  // stage 1: products
  logic                     v1_q;
  logic [2:0]               kind1_q;
  logic signed [SEC_W-1:0]  as1_q, bs1_q;
  logic [USEC_W-1:0]        au1_q, bu1_q;
  logic signed [DEN_W-1:0]  f1_q;
  logic signed [NUM_W-1:0]  at1_q, auf1_q;
  logic [SEC_W-1:0]         asf1_q;
  logic [1:0]               order1_q;
  logic signed [NUM_W-1:0]  at1_d, auf1_d;
  logic [SEC_W-1:0]         asf1_d;
  logic [1:0]               order1_d;

  // stage 2: sums
  logic                    v2_q;
  ctx_t                    ctx2_q, ctx2_d;
  logic signed [NUM_W-1:0] t2_q, t2_d;
  logic signed [DEN_W-1:0] f2_q;

  // stage 3: magnitudes
  logic             v3_q;
  ctx_t             ctx3_q;
  logic [NUM_W-1:0] mt3_q, mt3_d;
  logic [DEN_W-1:0] mf3_q, mf3_d;

  function automatic logic signed [NUM_W-1:0] a_sec_to_num(input logic signed [SEC_W-1:0] x);
    a_sec_to_num = NUM_W'(x);
  endfunction

  always_comb begin
    at1_d  = a_sec_to_num(as0_q) * USEC_S;
    auf1_d = $signed({1'b0, au0_q}) * f0_q;
    asf1_d = SEC_W'(as0_q * f0_q);
    if (as0_q != bs0_q) begin
      order1_d = (as0_q > bs0_q) ? ORDER_GT : ORDER_LT;
    end else if (au0_q != bu0_q) begin
      order1_d = (au0_q > bu0_q) ? ORDER_GT : ORDER_LT;
    end else begin
      order1_d = ORDER_EQ;
    end
  end

  always_comb begin
    ctx2_d       = '0;
    ctx2_d.kind  = kind1_q;
    ctx2_d.order = order1_q;
    t2_d         = at1_q + $signed({{(NUM_W-USEC_W){1'b0}}, au1_q});
    ctx2_d.neg   = t2_d[NUM_W-1] ^ f1_q[DEN_W-1];
    ctx2_d.dz    = (kind1_q == KIND_DIV) && (f1_q == '0);
    case (kind1_q)
      KIND_ADD: begin
        ctx2_d.base = SEC_W'(as1_q + bs1_q);
        ctx2_d.p    = NUM_W'(au1_q) + NUM_W'(bu1_q);
      end
      KIND_SUB, KIND_SMALL: begin
        ctx2_d.base = SEC_W'(as1_q - bs1_q);
        ctx2_d.p    = NUM_W'(au1_q) - NUM_W'(bu1_q);
      end
      KIND_MUL: begin
        ctx2_d.base = asf1_q;
        ctx2_d.p    = auf1_q;
      end
      default: begin
        ctx2_d.base = '0;
        ctx2_d.p    = '0;
      end
    endcase
  end

  always_comb begin
    mt3_d = t2_q[NUM_W-1] ? NUM_W'(-t2_q) : NUM_W'(t2_q);
    mf3_d = f2_q[DEN_W-1] ? DEN_W'(-f2_q) : DEN_W'(f2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind0_q  <= kind_i;
      as0_q    <= a_sec_i;
      au0_q    <= a_usec_i;
      bs0_q    <= b_sec_i;
      bu0_q    <= b_usec_i;
      f0_q     <= factor_i;
      kind1_q  <= kind0_q;
      as1_q    <= as0_q;
      au1_q    <= au0_q;
      bs1_q    <= bs0_q;
      bu1_q    <= bu0_q;
      f1_q     <= f0_q;
      at1_q    <= at1_d;
      auf1_q   <= auf1_d;
      asf1_q   <= asf1_d;
      order1_q <= order1_d;
      ctx2_q   <= ctx2_d;
      t2_q     <= t2_d;
      f2_q     <= f1_q;
      ctx3_q   <= ctx2_q;
      mt3_q    <= mt3_d;
      mf3_q    <= mf3_d;
    end
  end

  assign valid_o = v3_q;
  assign mt_o    = mt3_q;
  assign mf_o    = mf3_q;
  assign ctx_o   = ctx3_q;

endmodule

/* hdl/sec_usec_time_alu.sv */
// ----------------------------------------------------------------------------
// sec_usec_time_alu
// Add, subtract, compare, multiply, divide and small difference on time
// values held as signed seconds plus microseconds.
// ----------------------------------------------------------------------------
// One item is taken every cycle while the pipeline is not held. Most of the
// pipeline is the bit-per-stage divider of 53 stages that divides the total
// microseconds by the factor. Four front stages, one stage ahead of the
// microsecond split, six split stages (a reciprocal product and a remainder
// stage for each of three 16-bit chunks) and two final stages make up the
// rest. The whole pipeline holds while a finished result is not taken.
module sec_usec_time_alu import stalu_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [135:0]  s_axis_tdata,  // a_sec, a_usec, b_sec, b_usec, factor
  input  logic [2:0]    s_axis_tuser,  // kind
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [87:0]   m_axis_tdata   // r_sec, r_usec, order, div_zero, small_ns,
                                       // fits_small, zero pad
);

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic             fv;
  logic [NUM_W-1:0] fmt;
  logic [DEN_W-1:0] fmf;
  ctx_t             fctx;

  stalu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid),
    .kind_i   (s_axis_tuser),
    .a_sec_i  (s_axis_tdata[31:0]),
    .a_usec_i (s_axis_tdata[51:32]),
    .b_sec_i  (s_axis_tdata[83:52]),
    .b_usec_i (s_axis_tdata[103:84]),
    .factor_i (s_axis_tdata[135:104]),
    .valid_o  (fv),
    .mt_o     (fmt),
    .mf_o     (fmf),
    .ctx_o    (fctx)
  );

  logic             d1v;
  logic [NUM_W-1:0] d1q;
  logic [DEN_W-1:0] d1r;
  ctx_t             d1ctx;

  stalu_div u_div_factor (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fv),
    .num_i   (fmt),
    .den_i   (fmf),
    .ctx_i   (fctx),
    .valid_o (d1v),
    .quo_o   (d1q),
    .rem_o   (d1r),
    .ctx_o   (d1ctx)
  );

  // pick the value to split and take its magnitude
  logic             v4_q;
  ctx_t             ctx4_q, ctx4_d;
  logic [NUM_W-1:0] mag4_q, mag4_d;

  always_comb begin
    ctx4_d = d1ctx;
    if (d1ctx.kind == KIND_DIV) begin
      mag4_d      = d1q;
      ctx4_d.base = '0;
    end else begin
      mag4_d     = d1ctx.p[NUM_W-1] ? NUM_W'(-d1ctx.p) : NUM_W'(d1ctx.p);
      ctx4_d.neg = d1ctx.p[NUM_W-1];
    end
  end

  // split the magnitude into seconds and microseconds: set the six low bits
  // aside and divide the rest by 15625 one 16-bit chunk at a time, a
  // reciprocal product stage then a remainder stage per chunk
  logic               sa_v_q    [SPLIT_STEPS];
  ctx_t               sa_ctx_q  [SPLIT_STEPS];
  logic [SPLIT_W-1:0] sa_x_q    [SPLIT_STEPS];
  logic [QUO_W-1:0]   sa_quo_q  [SPLIT_STEPS];
  logic [Y_W-1:0]     sa_y_q    [SPLIT_STEPS];
  logic [PROD_W-1:0]  sa_prod_q [SPLIT_STEPS];
  logic               sb_v_q    [SPLIT_STEPS];
  ctx_t               sb_ctx_q  [SPLIT_STEPS];
  logic [SPLIT_W-1:0] sb_x_q    [SPLIT_STEPS];
  logic [QUO_W-1:0]   sb_quo_q  [SPLIT_STEPS];
  logic [ODD_W-1:0]   sb_rem_q  [SPLIT_STEPS];

  for (genvar s = 0; s < SPLIT_STEPS; s++) begin : g_split
    logic               v_in;
    ctx_t               ctx_in;
    logic [SPLIT_W-1:0] x_in;
    logic [QUO_W-1:0]   quo_in;
    logic [ODD_W-1:0]   rem_in;
    logic [Y_W-1:0]     y_d;
    logic [PROD_W-1:0]  prod_d;
    logic [CHUNK_W-1:0] digit;
    logic [Y_W-1:0]     back;
    logic [ODD_W-1:0]   rem_d;

    if (s == 0) begin : g_first
      assign v_in   = v4_q;
      assign ctx_in = ctx4_q;
      assign x_in   = SPLIT_W'(mag4_q);
      assign quo_in = '0;
      assign rem_in = '0;
    end else begin : g_next
      assign v_in   = sb_v_q[s-1];
      assign ctx_in = sb_ctx_q[s-1];
      assign x_in   = sb_x_q[s-1];
      assign quo_in = sb_quo_q[s-1];
      assign rem_in = sb_rem_q[s-1];
    end

    // bring down the next chunk behind the running remainder
    assign y_d    = {rem_in, x_in[USEC_SHIFT + CHUNK_W*(SPLIT_STEPS-1-s) +: CHUNK_W]};
    assign prod_d = PROD_W'(y_d) * PROD_W'(RECIP_M);
    assign digit  = sa_prod_q[s][RECIP_SHIFT +: CHUNK_W];
    assign back   = Y_W'(digit) * Y_W'(USEC_ODD);
    assign rem_d  = ODD_W'(sa_y_q[s] - back);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sa_v_q[s] <= 1'b0;
        sb_v_q[s] <= 1'b0;
      end else if (en) begin
        sa_v_q[s] <= v_in;
        sb_v_q[s] <= sa_v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sa_ctx_q[s]  <= ctx_in;
        sa_x_q[s]    <= x_in;
        sa_quo_q[s]  <= quo_in;
        sa_y_q[s]    <= y_d;
        sa_prod_q[s] <= prod_d;
        sb_ctx_q[s]  <= sa_ctx_q[s];
        sb_x_q[s]    <= sa_x_q[s];
        sb_quo_q[s]  <= {sa_quo_q[s][QUO_W-CHUNK_W-1:0], digit};
        sb_rem_q[s]  <= rem_d;
      end
    end
  end

  logic              d2v;
  logic [QUO_W-1:0]  d2q;
  logic [USEC_W-1:0] d2r;
  ctx_t              d2ctx;

  assign d2v   = sb_v_q[SPLIT_STEPS-1];
  assign d2q   = sb_quo_q[SPLIT_STEPS-1];
  assign d2r   = {sb_rem_q[SPLIT_STEPS-1], sb_x_q[SPLIT_STEPS-1][USEC_SHIFT-1:0]};
  assign d2ctx = sb_ctx_q[SPLIT_STEPS-1];

  // floor correction for negative values
  logic              v6_q;
  ctx_t              ctx6_q;
  logic [SEC_W-1:0]  sec6_q, sec6_d, qlow;
  logic [USEC_W-1:0] usec6_q, usec6_d;
  logic              rnz;

  always_comb begin
    rnz = d2r != '0;
    if (!d2ctx.neg) begin
      qlow    = d2q[SEC_W-1:0];
      usec6_d = d2r;
    end else if (rnz) begin
      qlow    = ~d2q[SEC_W-1:0];
      usec6_d = USEC_W'(USEC_PER_SEC) - d2r;
    end else begin
      qlow    = SEC_W'(-d2q[SEC_W-1:0]);
      usec6_d = '0;
    end
    sec6_d = d2ctx.base + qlow;
  end

  // result formatting
  logic              vo_q;
  logic [SEC_W-1:0]  rsec_q, rsec_d;
  logic [USEC_W-1:0] rusec_q, rusec_d;
  logic [1:0]        order_q, order_d;
  logic              dz_q, dz_d, fits_q, fits_d;
  logic [NS_W-1:0]   sns_q, sns_d;

  always_comb begin
    rsec_d  = '0;
    rusec_d = '0;
    order_d = ORDER_EQ;
    dz_d    = 1'b0;
    fits_d  = 1'b0;
    sns_d   = '0;
    case (ctx6_q.kind)
      KIND_ADD, KIND_SUB, KIND_MUL: begin
        rsec_d  = sec6_q;
        rusec_d = usec6_q;
      end
      KIND_DIV: begin
        if (ctx6_q.dz) begin
          dz_d = 1'b1;
        end else begin
          rsec_d  = sec6_q;
          rusec_d = usec6_q;
        end
      end
      KIND_SMALL: begin
        rsec_d  = sec6_q;
        rusec_d = usec6_q;
        if (sec6_q == '0) begin
          fits_d = 1'b1;
          sns_d  = NS_W'(usec6_q) * NS_W'(NS_PER_USEC);
        end
      end
      KIND_CMP: begin
        order_d = ctx6_q.order;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v6_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v4_q <= d1v;
      v6_q <= d2v;
      vo_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx4_q  <= ctx4_d;
      mag4_q  <= mag4_d;
      ctx6_q  <= d2ctx;
      sec6_q  <= sec6_d;
      usec6_q <= usec6_d;
      rsec_q  <= rsec_d;
      rusec_q <= rusec_d;
      order_q <= order_d;
      dz_q    <= dz_d;
      fits_q  <= fits_d;
      sns_q   <= sns_d;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = {2'b00, fits_q, sns_q, dz_q, order_q, rusec_q, rsec_q};

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && dz_q) |-> (rsec_q == '0 && rusec_q == '0))
    else $error("divide by zero gave a nonzero time");

  a_usec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (rusec_q < USEC_W'(USEC_PER_SEC)))
    else $error("microseconds out of range");

  a_fits_sec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && fits_q) |->
      (rsec_q == '0 && sns_q == NS_W'(rusec_q) * NS_W'(NS_PER_USEC)))
    else $error("small difference inconsistent with result time");

  a_order_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && order_q != ORDER_EQ) |-> (rsec_q == '0 && !dz_q && !fits_q))
    else $error("compare result mixed with other fields");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sec_usec_time_alu: a directed table followed by
// random items; every result is compared field by field against a typed
// value or a local time-arithmetic model, with random idling on both streams.
// ----------------------------------------------------------------------------
module tb_top;
  import stalu_pkg::*;

  localparam logic [2:0] KIND_RSVD6 = 3'd6;
  localparam logic [2:0] KIND_RSVD7 = 3'd7;
  localparam int         N_RANDOM   = 400;
  localparam int         DRAIN_CYC  = 150;
  localparam int         HOLD_CYC   = 300;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] a_sec;
    logic [19:0]        a_usec;
    logic signed [31:0] b_sec;
    logic [19:0]        b_usec;
    logic signed [31:0] factor;
  } op_t;

  typedef struct packed {
    logic signed [31:0] sec;
    logic [19:0]        usec;
    logic [1:0]         order;
    logic               dz;
    logic [29:0]        ns;
    logic               fits;
  } tval_t;

  typedef struct {
    op_t   op;
    bit    typed;
    tval_t res;
  } row_t;

  logic          clk_i;
  logic          rst_ni;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [135:0]  s_axis_tdata;
  logic [2:0]    s_axis_tuser;
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  logic [87:0]   m_axis_tdata;

  tval_t pending_q[$];
  int    n_errors;
  bit    quiet;      // no idling on either side while set
  bit    hold_req;   // asks the receiver for one long hold-off

  sec_usec_time_alu u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // floor split of a microsecond count into seconds and microseconds
  function automatic void split_usec(input longint p, output longint q, output longint r);
    q = p / longint'(USEC_PER_SEC);
    r = p % longint'(USEC_PER_SEC);
    if (r < 0) begin
      r += USEC_PER_SEC;
      q -= 1;
    end
  endfunction

  function automatic tval_t time_alu(input op_t op);
    tval_t  t;
    longint as, au, bs, bu, f, q, r, tot, mt, mf, mq;
    as = op.a_sec;
    au = longint'(op.a_usec);
    bs = op.b_sec;
    bu = longint'(op.b_usec);
    f  = op.factor;
    t  = '0;
    case (op.kind)
      KIND_ADD: begin
        split_usec(au + bu, q, r);
        t.sec  = 32'(as + bs + q);
        t.usec = 20'(r);
      end
      KIND_SUB, KIND_SMALL: begin
        split_usec(au - bu, q, r);
        t.sec  = 32'(as - bs + q);
        t.usec = 20'(r);
        if (op.kind == KIND_SMALL && t.sec == 0) begin
          t.fits = 1'b1;
          t.ns   = 30'(r * NS_PER_USEC);
        end
      end
      KIND_CMP: begin
        if (as != bs) t.order = (as > bs) ? ORDER_GT : ORDER_LT;
        else if (au != bu) t.order = (au > bu) ? ORDER_GT : ORDER_LT;
        else t.order = ORDER_EQ;
      end
      KIND_MUL: begin
        split_usec(au * f, q, r);
        t.sec  = 32'(as * f + q);
        t.usec = 20'(r);
      end
      KIND_DIV: begin
        if (f == 0) begin
          t.dz = 1'b1;
        end else begin
          tot = as * longint'(USEC_PER_SEC) + au;
          mt  = (tot < 0) ? -tot : tot;
          mf  = (f < 0) ? -f : f;
          mq  = mt / mf;
          split_usec(((tot < 0) != (f < 0)) ? -mq : mq, q, r);
          t.sec  = 32'(q);
          t.usec = 20'(r);
        end
      end
      default: t = '0;
    endcase
    return t;
  endfunction

  task automatic report(input string fld, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, fld, got, want);
    n_errors++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    tval_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[31:0], m_axis_tdata[51:32], m_axis_tdata[53:52],
             m_axis_tdata[54], m_axis_tdata[84:55], m_axis_tdata[85]};
      if (pending_q.size() == 0) begin
        $display("%0t: result item with nothing expected", $realtime);
        n_errors++;
      end else begin
        want = pending_q.pop_front();
        if (got.sec   != want.sec)   report("r_sec", got.sec, want.sec);
        if (got.usec  != want.usec)  report("r_usec", got.usec, want.usec);
        if (got.order != want.order) report("order", got.order, want.order);
        if (got.dz    != want.dz)    report("div_zero", got.dz, want.dz);
        if (got.ns    != want.ns)    report("small_ns", got.ns, want.ns);
        if (got.fits  != want.fits)  report("fits_small", got.fits, want.fits);
      end
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int hold_cnt;
    m_axis_tready = 1'b0;
    hold_cnt = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYC;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 37);
      end
    end
  end

  task automatic send(input op_t op, input tval_t want);
    while (!quiet && $urandom_range(99) < 37) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op.kind;
    s_axis_tdata  <= {op.factor, op.b_usec, op.b_sec, op.a_usec, op.a_sec};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_q.push_back(want);
  endtask

  function automatic logic [19:0] rand_usec();
    return ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(999999));
  endfunction

  function automatic logic signed [31:0] rand_sec();
    case ($urandom_range(3))
      0:       return 32'($urandom);
      1:       return $signed(32'($urandom_range(2000))) - 1000;
      2:       return ($urandom_range(1)) ? 32'h7fffffff - $urandom_range(3)
                                          : 32'h80000000 + $urandom_range(3);
      default: return $signed(32'($urandom_range(8))) - 4;
    endcase
  endfunction

  function automatic op_t rand_op();
    op_t op;
    op.kind   = ($urandom_range(19) == 0) ? 3'($urandom_range(7))
                                          : 3'($urandom_range(int'(KIND_SMALL)));
    op.a_sec  = rand_sec();
    op.a_usec = rand_usec();
    op.b_sec  = rand_sec();
    op.b_usec = rand_usec();
    // keep operands close now and then so the small difference fits
    if (op.kind == KIND_SMALL && $urandom_range(1)) op.b_sec = op.a_sec - $urandom_range(1);
    case ($urandom_range(3))
      0:       op.factor = 32'($urandom);
      1:       op.factor = $signed(32'($urandom_range(20))) - 10;
      2:       op.factor = $signed(32'($urandom_range(2000000))) - 1000000;
      default: op.factor = ($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
    endcase
    return op;
  endfunction

  initial begin
    row_t  rows[$];
    op_t   op;
    tval_t zero;
    zero = '0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_ADD;
    n_errors      = 0;
    quiet         = 1'b0;
    hold_req      = 1'b0;

    rows.push_back('{'{KIND_ADD, 0, 0, 0, 0, 0}, 1, zero});
    rows.push_back('{'{KIND_ADD, 32'sh7fffffff, 999999, 0, 1, 0}, 1,
                     '{32'sh80000000, 0, ORDER_EQ, 0, 0, 0}});
    rows.push_back('{'{KIND_SUB, 32'sh80000000, 0, 1, 0, 0}, 1,
                     '{32'sh7fffffff, 0, ORDER_EQ, 0, 0, 0}});
    rows.push_back('{'{KIND_CMP, 5, 10, 5, 10, 0}, 1, zero});
    rows.push_back('{'{KIND_CMP, 32'sh7fffffff, 0, 32'sh80000000, 0, 0}, 1,
                     '{0, 0, ORDER_GT, 0, 0, 0}});
    rows.push_back('{'{KIND_CMP, 3, 20'hfffff, 3, 20'hffffe, 0}, 1,
                     '{0, 0, ORDER_GT, 0, 0, 0}});
    rows.push_back('{'{KIND_CMP, -1, 0, 0, 0, 0}, 1, '{0, 0, ORDER_LT, 0, 0, 0}});
    rows.push_back('{'{KIND_DIV, 12, 345, 0, 0, 0}, 1, '{0, 0, ORDER_EQ, 1, 0, 0}});
    rows.push_back('{'{KIND_RSVD6, 7, 7, 7, 7, 7}, 1, zero});
    rows.push_back('{'{KIND_RSVD7, -1, 20'hfffff, -1, 20'hfffff, -1}, 1, zero});
    rows.push_back('{'{KIND_ADD, -1, 20'hfffff, -1, 20'hfffff, 0}, 0, zero});
    rows.push_back('{'{KIND_SUB, 0, 0, 0, 20'hfffff, 0}, 0, zero});
    rows.push_back('{'{KIND_MUL, 32'sh80000000, 20'hfffff, 0, 0, 32'sh80000000}, 0, zero});
    rows.push_back('{'{KIND_MUL, 32'sh7fffffff, 999999, 0, 0, 32'sh7fffffff}, 0, zero});
    rows.push_back('{'{KIND_MUL, -1, 750000, 0, 0, -3}, 0, zero});
    rows.push_back('{'{KIND_DIV, 32'sh80000000, 0, 0, 0, -1}, 0, zero});
    rows.push_back('{'{KIND_DIV, 32'sh7fffffff, 20'hfffff, 0, 0, 32'sh80000000}, 0, zero});
    rows.push_back('{'{KIND_DIV, -1, 1, 0, 0, 7}, 0, zero});
    rows.push_back('{'{KIND_SMALL, 10, 999999, 10, 0, 0}, 0, zero});
    rows.push_back('{'{KIND_SMALL, 10, 0, 10, 1, 0}, 0, zero});
    rows.push_back('{'{KIND_SMALL, 11, 0, 10, 999999, 0}, 0, zero});
    rows.push_back('{'{KIND_SMALL, 32'sh80000000, 0, 32'sh7fffffff, 0, 0}, 0, zero});

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send(rows[i].op, rows[i].typed ? rows[i].res : time_alu(rows[i].op));

    for (int n = 0; n < N_RANDOM; n++) begin
      quiet = (n >= 150 && n < 250);
      if (n == 60) hold_req = 1'b1;
      if (n == 300) begin
        s_axis_tvalid <= 1'b0;
        wait (pending_q.size() == 0);
        @(posedge clk_i);
      end
      op = rand_op();
      send(op, time_alu(op));
    end
    s_axis_tvalid <= 1'b0;
    quiet = 1'b0;

    wait (pending_q.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("tb_top failed");
    $finish;
  end

endmodule
